// ===== src/lru_key_value_cache_defines.svh =====
// assertion macros for the lru key/value cache checker
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LKVC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define LKVC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/lkvc_pkg.sv =====
package lkvc_pkg;

   // field widths
   localparam int KEY_W = 32;
   localparam int VAL_W = 32;
   localparam int CAP_W = 5;

   // capacity after reset
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // request codes
   typedef enum logic [1:0] {
      REQ_GET    = 2'd0,
      REQ_SET    = 2'd1,
      REQ_REMOVE = 2'd2
   } req_kind_type;

endpackage

// ===== src/lru_key_value_cache.sv =====
// path: a transaction accepted into the input register moves, after one lookup and update
// pass, into the result register, where it can be taken
// throughput: one transaction per cycle, set by the parallel key compare and rank
// update over all entries in one pass; result register stalls only on rsp_ready
// reset: synchronous, clears all valid bits and occupancy, capacity returns to 16
module lru_key_value_cache #(
   parameter int ENTRIES = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_type,
   input  logic [lkvc_pkg::KEY_W-1:0]   req_lookup_key,
   input  logic [lkvc_pkg::VAL_W-1:0]   req_entry_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_hit,
   output logic [lkvc_pkg::VAL_W-1:0]   rsp_read_value,
   output logic                         rsp_flushed,
   output logic [lkvc_pkg::KEY_W-1:0]   rsp_flushed_key,
   output logic [lkvc_pkg::VAL_W-1:0]   rsp_flushed_value,
   input  logic                         csr_write_enable,
   input  logic [lkvc_pkg::CAP_W-1:0]   csr_write_data
);
   import lkvc_pkg::*;

   localparam int RW   = $clog2(ENTRIES);
   localparam int OW   = $clog2(ENTRIES + 1);
   localparam int CMPW = (OW > CAP_W) ? OW : CAP_W;

   // input register
   logic              in_valid_ff, in_valid_in;
   logic [1:0]        in_type_ff;
   logic [KEY_W-1:0]  in_key_ff;
   logic [VAL_W-1:0]  in_value_ff;

   // table state
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [KEY_W-1:0]   key_ff    [ENTRIES];
   logic [KEY_W-1:0]   key_in    [ENTRIES];
   logic [VAL_W-1:0]   handle_ff [ENTRIES];
   logic [VAL_W-1:0]   handle_in [ENTRIES];
   logic [RW-1:0]      rank_ff   [ENTRIES];
   logic [RW-1:0]      rank_in   [ENTRIES];
   logic [OW-1:0]      occ_ff, occ_in;
   logic [CAP_W-1:0]   cap_ff, cap_in;

   // result register
   logic              out_valid_ff, out_valid_in;
   logic              hit_ff, hit_in;
   logic [VAL_W-1:0]  read_ff, read_in;
   logic              flushed_ff, flushed_in;
   logic [KEY_W-1:0]  fkey_ff, fkey_in;
   logic [VAL_W-1:0]  fval_ff, fval_in;

   logic fire;

   // lookup terms
   logic [ENTRIES-1:0] match;
   logic [ENTRIES-1:0] victim;
   logic [ENTRIES-1:0] free_slots;
   logic [ENTRIES-1:0] ins_slot;
   logic               hit_any;
   logic [VAL_W-1:0]   hit_handle;
   logic [RW-1:0]      hit_rank;
   logic [KEY_W-1:0]   victim_key;
   logic [VAL_W-1:0]   victim_handle;
   logic [RW-1:0]      oldest_rank;
   logic [CMPW-1:0]    cap_clamp;
   logic               need_evict;

   // handshake: the input stage moves whenever the result register can take it
   assign fire        = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || fire;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !fire);

   // effective capacity, clamped to 1 .. ENTRIES
   always_comb begin
      cap_clamp = CMPW'(cap_ff);
      if (cap_clamp == '0) begin
         cap_clamp = CMPW'(1);
      end else if (cap_clamp > CMPW'(ENTRIES)) begin
         cap_clamp = CMPW'(ENTRIES);
      end
      need_evict  = CMPW'(occ_ff) >= cap_clamp;
      oldest_rank = RW'(occ_ff - OW'(1));
   end

   // parallel compare against every slot
   always_comb begin
      hit_handle    = '0;
      hit_rank      = '0;
      victim_key    = '0;
      victim_handle = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match[i]  = valid_ff[i] && (key_ff[i] == in_key_ff);
         victim[i] = valid_ff[i] && (rank_ff[i] == oldest_rank);
         if (match[i]) begin
            hit_handle |= handle_ff[i];
            hit_rank   |= rank_ff[i];
         end
         if (victim[i]) begin
            victim_key    |= key_ff[i];
            victim_handle |= handle_ff[i];
         end
      end
      hit_any    = |match;
      free_slots = ~valid_ff | (need_evict ? victim : '0);
      ins_slot   = free_slots & (~free_slots + ENTRIES'(1));
   end

   // table update and result for the transaction in the input register
   always_comb begin
      valid_in   = valid_ff;
      key_in     = key_ff;
      handle_in  = handle_ff;
      rank_in    = rank_ff;
      occ_in     = occ_ff;
      hit_in     = 1'b0;
      read_in    = '0;
      flushed_in = 1'b0;
      fkey_in    = '0;
      fval_in    = '0;
      if (fire) begin
         case (in_type_ff)
            REQ_GET: begin
               if (hit_any) begin
                  hit_in  = 1'b1;
                  read_in = hit_handle;
                  // touch: younger entries age by one
                  for (int i = 0; i < ENTRIES; i++) begin
                     if (match[i]) begin
                        rank_in[i] = '0;
                     end else if (valid_ff[i] && rank_ff[i] < hit_rank) begin
                        rank_in[i] = rank_ff[i] + RW'(1);
                     end
                  end
               end
            end
            REQ_SET: begin
               if (hit_any) begin
                  hit_in = 1'b1;
                  for (int i = 0; i < ENTRIES; i++) begin
                     if (match[i]) begin
                        handle_in[i] = in_value_ff;
                        rank_in[i]   = '0;
                     end else if (valid_ff[i] && rank_ff[i] < hit_rank) begin
                        rank_in[i] = rank_ff[i] + RW'(1);
                     end
                  end
               end else begin
                  // evict the oldest entry when full, then insert as newest
                  if (need_evict) begin
                     flushed_in = 1'b1;
                     fkey_in    = victim_key;
                     fval_in    = victim_handle;
                  end else begin
                     occ_in = occ_ff + OW'(1);
                  end
                  for (int i = 0; i < ENTRIES; i++) begin
                     if (ins_slot[i]) begin
                        valid_in[i]  = 1'b1;
                        key_in[i]    = in_key_ff;
                        handle_in[i] = in_value_ff;
                        rank_in[i]   = '0;
                     end else if (need_evict && victim[i]) begin
                        valid_in[i] = 1'b0;
                     end else if (valid_ff[i]) begin
                        rank_in[i] = rank_ff[i] + RW'(1);
                     end
                  end
               end
            end
            REQ_REMOVE: begin
               if (hit_any) begin
                  hit_in     = 1'b1;
                  flushed_in = 1'b1;
                  fkey_in    = in_key_ff;
                  fval_in    = hit_handle;
                  occ_in     = occ_ff - OW'(1);
                  // drop: older entries move up by one
                  for (int i = 0; i < ENTRIES; i++) begin
                     if (match[i]) begin
                        valid_in[i] = 1'b0;
                     end else if (valid_ff[i] && rank_ff[i] > hit_rank) begin
                        rank_in[i] = rank_ff[i] - RW'(1);
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // result register valid
   assign out_valid_in = fire || (out_valid_ff && !rsp_ready);

   // capacity register
   assign cap_in = csr_write_enable ? csr_write_data : cap_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         valid_ff     <= '0;
         occ_ff       <= '0;
         cap_ff       <= CAP_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         valid_ff     <= valid_in;
         occ_ff       <= occ_in;
         cap_ff       <= cap_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_type_ff  <= req_type;
         in_key_ff   <= req_lookup_key;
         in_value_ff <= req_entry_value;
      end
      key_ff    <= key_in;
      handle_ff <= handle_in;
      rank_ff   <= rank_in;
      if (fire) begin
         hit_ff     <= hit_in;
         read_ff    <= read_in;
         flushed_ff <= flushed_in;
         fkey_ff    <= fkey_in;
         fval_ff    <= fval_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_hit           = hit_ff;
   assign rsp_read_value    = read_ff;
   assign rsp_flushed       = flushed_ff;
   assign rsp_flushed_key   = fkey_ff;
   assign rsp_flushed_value = fval_ff;

endmodule

// ===== src/lkvc_checker.sv =====
`include "lru_key_value_cache_defines.svh"

module lkvc_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_hit,
   input logic [lkvc_pkg::VAL_W-1:0]   rsp_read_value,
   input logic                         rsp_flushed,
   input logic [lkvc_pkg::KEY_W-1:0]   rsp_flushed_key,
   input logic [lkvc_pkg::VAL_W-1:0]   rsp_flushed_value
);
   import lkvc_pkg::*;

   // a stalled result transaction holds
   `LKVC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_hit) && $stable(rsp_read_value) && $stable(rsp_flushed) && $stable(rsp_flushed_key) && $stable(rsp_flushed_value), "result changed while stalled")

   // a returned handle only comes from a hit
   `LKVC_ASSERT_NOW(a_read_needs_hit, clock, reset, rsp_valid && (rsp_read_value != '0), rsp_hit, "read value without hit")

   // no flush means no flushed key or handle
   `LKVC_ASSERT_NOW(a_flush_fields, clock, reset, rsp_valid && !rsp_flushed, (rsp_flushed_key == '0) && (rsp_flushed_value == '0), "flushed fields set without flush")

   // a get with a handle never also flushes
   `LKVC_ASSERT_NOW(a_get_no_flush, clock, reset, rsp_valid && (rsp_read_value != '0), !rsp_flushed, "flush reported on a get")

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (.*);
